// ----- hdl/sparse_triple_merge_add_defines.svh -----
// assertion macros for the sparse triple merge adder
// no dependencies; taken in by the files that carry assertions
`ifndef SPARSE_TRIPLE_MERGE_ADD_DEFINES_SVH
`define SPARSE_TRIPLE_MERGE_ADD_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define STMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define STMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define STMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/stma_pkg.sv -----
// shared types and codes for the sparse triple merge adder
// no dependencies
package stma_pkg;

	localparam int RowW = 10;
	localparam int ColW = 10;
	localparam int ValW = 16;
	localparam int SumW = 17;

	typedef enum logic [1:0] {
		CmdLoadA = 2'd0,
		CmdLoadB = 2'd1,
		CmdRun   = 2'd2,
		CmdNone  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		StIdle   = 2'd0,
		StMerge  = 2'd1,
		StFinish = 2'd2
	} state_t;

	// one stored triple, 36 bits
	typedef struct packed {
		logic [RowW-1:0]        row;
		logic [ColW-1:0]        col;
		logic signed [ValW-1:0] val;
	} entry_t;

endpackage

// ----- hdl/sparse_triple_merge_add.sv -----
// sparse matrix addition by merging two sorted lists of nonzero triples
// depends on stma_pkg, stma_list_mem and sparse_triple_merge_add_defines.svh
//
// usage:
// - input channel (in_valid/in_ready) takes a command with a triple:
//   load into list A, load into list B, or run; the unused code is dropped
// - a load gives no item, so loads go one per cycle; a load into a full
//   list is dropped and remembered, and every item of the next run shows
//   overflow
// - a run walks both stores with one compare per cycle unless the output
//   stalls: equal keys are added (a zero sum is dropped), otherwise the
//   smaller key passes, and the tail of the longer list is appended
// - each result is held back one step so the final one can carry last;
//   a run that yields nothing gives a single item with empty_res and last
// - in a run, each merge step that yields a result moves the held result
//   to the output register and holds the new one; once both lists are
//   used up the run moves to the finish state, which sends the held
//   result with last and closes the run; the merge rate is set by the
//   single read port of each store and the one-entry hold register
// - in_ready is high only while no run is in progress
// - output channel (out_valid/out_ready) has an output register; while
//   the receiver stalls with a held result waiting, the merge pauses
// - reset clears the counts, the drop flag and all control; the stores
//   need no clearing since only written entries are ever read
// - after a run the counts and the drop flag return to zero
`include "sparse_triple_merge_add_defines.svh"

module sparse_triple_merge_add
	import stma_pkg::*;
#(
	parameter int LIST_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [RowW-1:0]        row,
	input  logic [ColW-1:0]        col,
	input  logic signed [ValW-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [RowW-1:0]        out_row,
	output logic [ColW-1:0]        out_col,
	output logic signed [SumW-1:0] out_value,
	output logic                   last,
	output logic                   empty_res,
	output logic                   overflow
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] Full = CW'(LIST_DEPTH);

	// control state
	state_t         state_q, state_d;
	logic [CW-1:0]  cnt_a_q, cnt_a_d;
	logic [CW-1:0]  cnt_b_q, cnt_b_d;
	logic [CW-1:0]  ia_q, ia_d;
	logic [CW-1:0]  ib_q, ib_d;
	logic           dropped_q, dropped_d;

	// result held back until the next one (or the end) is known
	logic                   pend_valid_q, pend_valid_d;
	logic [RowW-1:0]        pend_row_q, pend_row_d;
	logic [ColW-1:0]        pend_col_q, pend_col_d;
	logic signed [SumW-1:0] pend_val_q, pend_val_d;

	// output register
	logic                   out_valid_q, out_valid_d;
	logic [RowW-1:0]        out_row_q, out_row_d;
	logic [ColW-1:0]        out_col_q, out_col_d;
	logic signed [SumW-1:0] out_val_q, out_val_d;
	logic                   last_q, last_d;
	logic                   empty_q, empty_d;
	logic                   ovf_q, ovf_d;

	// store ports
	logic    wr_a, wr_b;
	entry_t  wr_entry;
	entry_t  rd_a, rd_b;

	// merge datapath
	logic                   out_free;
	logic                   a_has, b_has;
	logic [RowW+ColW-1:0]   key_a, key_b;
	logic signed [SumW-1:0] sum_ab;
	logic                   take_a, take_b;
	logic                   res_valid;
	logic [RowW-1:0]        res_row;
	logic [ColW-1:0]        res_col;
	logic signed [SumW-1:0] res_val;
	cmd_t                   cmd;

	assign cmd      = cmd_t'(command);
	assign out_free = !out_valid_q || out_ready;
	assign wr_entry = '{row: row, col: col, val: value};

	stma_list_mem #(.DEPTH(LIST_DEPTH)) u_mem_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (cnt_a_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (ia_d[AW-1:0]),
		.rd_data (rd_a)
	);

	stma_list_mem #(.DEPTH(LIST_DEPTH)) u_mem_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (cnt_b_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (ib_d[AW-1:0]),
		.rd_data (rd_b)
	);

	// compare the two list heads
	always_comb begin
		a_has     = ia_q < cnt_a_q;
		b_has     = ib_q < cnt_b_q;
		key_a     = {rd_a.row, rd_a.col};
		key_b     = {rd_b.row, rd_b.col};
		sum_ab    = SumW'(rd_a.val) + SumW'(rd_b.val);
		take_a    = 1'b0;
		take_b    = 1'b0;
		res_valid = 1'b0;
		res_row   = rd_a.row;
		res_col   = rd_a.col;
		res_val   = SumW'(rd_a.val);
		if (a_has && b_has) begin
			if (key_a == key_b) begin
				// matched coordinate: add, drop a zero sum
				take_a    = 1'b1;
				take_b    = 1'b1;
				res_valid = (sum_ab != '0);
				res_val   = sum_ab;
			end else if (key_a < key_b) begin
				take_a    = 1'b1;
				res_valid = 1'b1;
			end else begin
				take_b    = 1'b1;
				res_valid = 1'b1;
				res_row   = rd_b.row;
				res_col   = rd_b.col;
				res_val   = SumW'(rd_b.val);
			end
		end else if (a_has) begin
			take_a    = 1'b1;
			res_valid = 1'b1;
		end else if (b_has) begin
			take_b    = 1'b1;
			res_valid = 1'b1;
			res_row   = rd_b.row;
			res_col   = rd_b.col;
			res_val   = SumW'(rd_b.val);
		end
	end

	// next state and outputs
	always_comb begin
		state_d      = state_q;
		cnt_a_d      = cnt_a_q;
		cnt_b_d      = cnt_b_q;
		ia_d         = ia_q;
		ib_d         = ib_q;
		dropped_d    = dropped_q;
		pend_valid_d = pend_valid_q;
		pend_row_d   = pend_row_q;
		pend_col_d   = pend_col_q;
		pend_val_d   = pend_val_q;
		out_valid_d  = out_valid_q && !out_ready;
		out_row_d    = out_row_q;
		out_col_d    = out_col_q;
		out_val_d    = out_val_q;
		last_d       = last_q;
		empty_d      = empty_q;
		ovf_d        = ovf_q;
		wr_a         = 1'b0;
		wr_b         = 1'b0;
		in_ready     = 1'b0;
		case (state_q)
			StIdle: begin
				// ready is high here, so a valid item is accepted
				in_ready = 1'b1;
				if (in_valid) begin
					case (cmd)
						CmdLoadA: begin
							if (cnt_a_q < Full) begin
								wr_a    = 1'b1;
								cnt_a_d = cnt_a_q + 1'b1;
							end else begin
								dropped_d = 1'b1;
							end
						end
						CmdLoadB: begin
							if (cnt_b_q < Full) begin
								wr_b    = 1'b1;
								cnt_b_d = cnt_b_q + 1'b1;
							end else begin
								dropped_d = 1'b1;
							end
						end
						CmdRun: begin
							state_d = StMerge;
						end
						default: begin
						end
					endcase
				end
			end
			StMerge: begin
				if (!a_has && !b_has) begin
					state_d = StFinish;
				end else if (!pend_valid_q || out_free) begin
					ia_d = ia_q + CW'(take_a);
					ib_d = ib_q + CW'(take_b);
					if (res_valid) begin
						// the held result is now known not to be the last
						if (pend_valid_q) begin
							out_valid_d = 1'b1;
							out_row_d   = pend_row_q;
							out_col_d   = pend_col_q;
							out_val_d   = pend_val_q;
							last_d      = 1'b0;
							empty_d     = 1'b0;
							ovf_d       = dropped_q;
						end
						pend_valid_d = 1'b1;
						pend_row_d   = res_row;
						pend_col_d   = res_col;
						pend_val_d   = res_val;
					end
				end
			end
			StFinish: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					last_d       = 1'b1;
					ovf_d        = dropped_q;
					empty_d      = !pend_valid_q;
					out_row_d    = pend_valid_q ? pend_row_q : '0;
					out_col_d    = pend_valid_q ? pend_col_q : '0;
					out_val_d    = pend_valid_q ? pend_val_q : '0;
					pend_valid_d = 1'b0;
					cnt_a_d      = '0;
					cnt_b_d      = '0;
					ia_d         = '0;
					ib_d         = '0;
					dropped_d    = 1'b0;
					state_d      = StIdle;
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= StIdle;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			ia_q         <= '0;
			ib_q         <= '0;
			dropped_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_a_q      <= cnt_a_d;
			cnt_b_q      <= cnt_b_d;
			ia_q         <= ia_d;
			ib_q         <= ib_d;
			dropped_q    <= dropped_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		pend_row_q <= pend_row_d;
		pend_col_q <= pend_col_d;
		pend_val_q <= pend_val_d;
		out_row_q  <= out_row_d;
		out_col_q  <= out_col_d;
		out_val_q  <= out_val_d;
		last_q     <= last_d;
		empty_q    <= empty_d;
		ovf_q      <= ovf_d;
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_val_q;
	assign last      = last_q;
	assign empty_res = empty_q;
	assign overflow  = ovf_q;

	// read pointers never pass the fill counts
	`STMA_ASSERT_IMP(a_idx_in_range, clk, arst_n, 1'b1, (ia_q <= cnt_a_q && ib_q <= cnt_b_q), "read index beyond count")
	// a held result only exists during a run
	`STMA_ASSERT_IMP(pend_only_in_run, clk, arst_n, pend_valid_q, (state_q != StIdle), "held result while idle")
	// an empty run item is always the last one
	`STMA_ASSERT_IMP(empty_is_last, clk, arst_n, (out_valid_q && empty_q), last_q, "empty item without last")
	// closing a run clears the lists and the drop flag
	`STMA_ASSERT_NXT(run_close_clears, clk, arst_n, (state_q == StFinish && out_free), (cnt_a_q == '0 && cnt_b_q == '0 && !dropped_q && state_q == StIdle), "run close did not clear state")

endmodule

// ----- hdl/stma_list_mem.sv -----
// triple store: single write port, one registered read port
// depends on stma_pkg
module stma_list_mem
	import stma_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  entry_t                               wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output entry_t                               rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
